FILE: src/gbn_pkg.sv
// gbn_pkg: shared constants for the go-back-n sender window
// field widths, request and status codes, register indexes and defaults
// no dependencies
package gbn_pkg;

	// default parameter values
	localparam int SEQ_BITS_DEF   = 3;
	localparam int DATA_WIDTH_DEF = 8;

	// fixed field widths
	localparam int REQ_W    = 2;
	localparam int SEQ_FW   = 3;
	localparam int STATUS_W = 3;
	localparam int WIN_W    = 3;
	localparam int TMO_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	// request kinds
	localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
	localparam logic [REQ_W-1:0] REQ_ACK  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_TICK = 2'd2;
	localparam logic [REQ_W-1:0] REQ_NOP  = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_LOADED    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_LOAD_FULL = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ACK_SLID  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_ACK_STALE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_TICK_IDLE = 3'd4;
	localparam logic [STATUS_W-1:0] ST_TICK_SENT = 3'd5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd1;

	// register reset values
	localparam logic [WIN_W-1:0] WINDOW_SIZE_RST   = 3'd7;
	localparam logic [TMO_W-1:0] TIMEOUT_TICKS_RST = 16'd1;

	localparam logic [TMO_W-1:0] TIMER_MAX = 16'hFFFF;

endpackage

FILE: src/go_back_n_sender_window_top.sv
// go_back_n_sender_window_top: go-back-n sender window with its payload store
// depends on gbn_pkg
//
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tuser req_type, tdata data_byte, ack_num
// m_axis    out  m_axis_tvalid/tready      tuser status, tdata timed_out .. outstanding
// cfg       in   cfg_valid/cfg_ready       cfg_index, cfg_data
//
// one request per cycle while s_axis_tready is high; the result passes the read stage
// and then the output register before it is offered on m_axis
// window counters live in flops and update at the accepting edge; the payload
// store is a one-port-write, one-port-read memory with a registered read
// a two-entry result pipe (read stage, output register) lets input run on
// while a result waits; m_axis_tready low backs up into s_axis_tready
// asynchronous active-low reset clears counters, timer and valid flags
module go_back_n_sender_window_top #(
	parameter int SEQ_BITS   = gbn_pkg::SEQ_BITS_DEF,
	parameter int DATA_WIDTH = gbn_pkg::DATA_WIDTH_DEF,
	localparam int IN_TDW  = ((DATA_WIDTH + gbn_pkg::SEQ_FW + 7) / 8) * 8,
	localparam int OUT_TDW = ((DATA_WIDTH + 3 * gbn_pkg::SEQ_FW + 1 + 7) / 8) * 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input request stream
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [IN_TDW-1:0]                    s_axis_tdata,  // data_byte, ack_num, zero pad
	input  logic [gbn_pkg::REQ_W-1:0]            s_axis_tuser,  // req_type
	// result stream
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [OUT_TDW-1:0]                   m_axis_tdata,  // timed_out, frame_seq,
	                                                             // frame_data, base_seq,
	                                                             // outstanding, zero pad
	output logic [gbn_pkg::STATUS_W-1:0]         m_axis_tuser,  // status
	// configuration writes
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [gbn_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [gbn_pkg::CFG_DAT_W-1:0]        cfg_data
);

	localparam int DEPTH = 1 << SEQ_BITS;
	localparam int WW    = (SEQ_BITS > gbn_pkg::WIN_W) ? SEQ_BITS : gbn_pkg::WIN_W;
	localparam int FW    = gbn_pkg::SEQ_FW;

	typedef logic [SEQ_BITS-1:0] seq_t;

	// configuration registers
	logic [gbn_pkg::WIN_W-1:0] window_size_q;
	logic [gbn_pkg::TMO_W-1:0] timeout_ticks_q;

	// window control state
	seq_t                      base_q;
	seq_t                      next_q;
	seq_t                      held_q;
	logic [gbn_pkg::TMO_W-1:0] timer_cnt_q;
	logic                      timer_run_q;

	// payload store
	logic [DATA_WIDTH-1:0] store_mem [DEPTH];
	logic [DATA_WIDTH-1:0] rd_data_q;

	// read stage
	logic                          valid_s1;
	logic [gbn_pkg::STATUS_W-1:0]  status_s1;
	logic                          expired_s1;
	logic                          send_s1;
	logic [FW-1:0]                 fseq_s1;
	logic [FW-1:0]                 base_s1;
	logic [FW-1:0]                 outs_s1;

	// output register
	logic                          valid_s2;
	logic [gbn_pkg::STATUS_W-1:0]  status_s2;
	logic                          expired_s2;
	logic [FW-1:0]                 fseq_s2;
	logic [DATA_WIDTH-1:0]         fdata_s2;
	logic [FW-1:0]                 base_s2;
	logic [FW-1:0]                 outs_s2;

	// request fields
	logic [gbn_pkg::REQ_W-1:0] req_type;
	logic [DATA_WIDTH-1:0]     data_byte;
	logic [FW-1:0]             ack_num;

	logic in_acc;
	logic adv_s1;

	// next-state values
	seq_t                         base_d;
	seq_t                         next_d;
	seq_t                         held_d;
	logic [gbn_pkg::TMO_W-1:0]    cnt_d;
	logic                         run_d;
	logic [gbn_pkg::STATUS_W-1:0] status_d;
	logic                         expired_d;
	logic                         send_d;
	logic                         wr_en;
	seq_t                         wr_addr;
	seq_t                         rd_addr;
	logic [WW-1:0]                eff_win;
	seq_t                         ack_seq;
	seq_t                         flight;
	seq_t                         ack_dist;
	seq_t                         flight_d;

	assign req_type  = s_axis_tuser;
	assign data_byte = s_axis_tdata[DATA_WIDTH-1:0];
	assign ack_num   = s_axis_tdata[DATA_WIDTH +: FW];

	// handshakes
	assign adv_s1        = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	// effective window, capped below the sequence space
	always_comb begin
		if (WW'(window_size_q) > WW'(DEPTH - 1))
			eff_win = WW'(DEPTH - 1);
		else
			eff_win = WW'(window_size_q);
	end

	assign ack_seq  = SEQ_BITS'(ack_num);
	assign flight   = next_q - base_q;
	assign ack_dist = ack_seq - base_q;

	// window update for one request
	always_comb begin
		seq_t tick_flight;
		base_d    = base_q;
		next_d    = next_q;
		held_d    = held_q;
		cnt_d     = timer_cnt_q;
		run_d     = timer_run_q;
		status_d  = gbn_pkg::ST_TICK_IDLE;
		expired_d = 1'b0;
		send_d    = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = base_q + held_q;
		tick_flight = flight;
		case (req_type)
			gbn_pkg::REQ_LOAD: begin
				if (WW'(held_q) < eff_win) begin
					wr_en    = 1'b1;
					held_d   = held_q + seq_t'(1);
					status_d = gbn_pkg::ST_LOADED;
				end else begin
					status_d = gbn_pkg::ST_LOAD_FULL;
				end
			end
			gbn_pkg::REQ_ACK: begin
				if (ack_dist != '0 && ack_dist <= flight) begin
					base_d   = ack_seq;
					held_d   = (held_q >= ack_dist) ? held_q - ack_dist : '0;
					cnt_d    = '0;
					run_d    = (flight != ack_dist);
					status_d = gbn_pkg::ST_ACK_SLID;
				end else begin
					status_d = gbn_pkg::ST_ACK_STALE;
				end
			end
			gbn_pkg::REQ_TICK: begin
				if (timer_run_q) begin
					if (timer_cnt_q != gbn_pkg::TIMER_MAX)
						cnt_d = timer_cnt_q + 16'd1;
					if (cnt_d >= timeout_ticks_q) begin
						expired_d = 1'b1;
						next_d    = base_q;
						cnt_d     = '0;
						run_d     = 1'b0;
					end
				end
				tick_flight = next_d - base_q;
				if (tick_flight < held_q && WW'(tick_flight) < eff_win) begin
					send_d = 1'b1;
					if (tick_flight == '0) begin
						run_d = 1'b1;
						cnt_d = '0;
					end
					next_d   = next_d + seq_t'(1);
					status_d = gbn_pkg::ST_TICK_SENT;
				end
			end
			default: begin
				status_d = gbn_pkg::ST_TICK_IDLE;
			end
		endcase
		rd_addr = next_d - seq_t'(send_d);
	end

	assign flight_d = next_d - base_d;

	// control and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q   <= gbn_pkg::WINDOW_SIZE_RST;
			timeout_ticks_q <= gbn_pkg::TIMEOUT_TICKS_RST;
			base_q          <= '0;
			next_q          <= '0;
			held_q          <= '0;
			timer_cnt_q     <= '0;
			timer_run_q     <= 1'b0;
			valid_s1        <= 1'b0;
			valid_s2        <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					gbn_pkg::REG_WINDOW_SIZE:   window_size_q   <= cfg_data[gbn_pkg::WIN_W-1:0];
					gbn_pkg::REG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data;
					default: ;
				endcase
			end
			if (in_acc) begin
				base_q      <= base_d;
				next_q      <= next_d;
				held_q      <= held_d;
				timer_cnt_q <= cnt_d;
				timer_run_q <= run_d;
			end
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (adv_s1)
				valid_s2 <= valid_s1;
		end
	end

	// payload store, registered read
	always_ff @(posedge clk) begin
		if (in_acc && wr_en)
			store_mem[wr_addr] <= data_byte;
		if (in_acc)
			rd_data_q <= store_mem[rd_addr];
	end

	// result payload pipe
	always_ff @(posedge clk) begin
		if (in_acc) begin
			status_s1  <= status_d;
			expired_s1 <= expired_d;
			send_s1    <= send_d;
			fseq_s1    <= send_d ? FW'(rd_addr) : '0;
			base_s1    <= FW'(base_d);
			outs_s1    <= FW'(flight_d);
		end
		if (adv_s1 && valid_s1) begin
			status_s2  <= status_s1;
			expired_s2 <= expired_s1;
			fseq_s2    <= fseq_s1;
			fdata_s2   <= send_s1 ? rd_data_q : '0;
			base_s2    <= base_s1;
			outs_s2    <= outs_s1;
		end
	end

	// result stream
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = status_s2;
	assign m_axis_tdata  = OUT_TDW'({outs_s2, base_s2, fdata_s2, fseq_s2, expired_s2});

`ifndef SYNTHESIS
	// frames in flight never exceed frames held
	a_flight_le_held: assert property (@(posedge clk) disable iff (!arst_n)
		(next_q - base_q) <= held_q)
		else $error("frames in flight exceed frames held");

	// timer runs exactly while frames are outstanding
	a_timer_matches_flight: assert property (@(posedge clk) disable iff (!arst_n)
		timer_run_q == ((next_q - base_q) != '0))
		else $error("timer state disagrees with outstanding frames");

	// a result that sent nothing carries no frame
	a_idle_no_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && status_s2 != gbn_pkg::ST_TICK_SENT) |-> (fdata_s2 == '0 && fseq_s2 == '0))
		else $error("frame fields set on a result that sent nothing");

	// an expiry rewinds the send number to the base
	a_expiry_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && expired_d && !send_d) |=> (next_q == base_q))
		else $error("expiry did not rewind to the base");
`endif

endmodule
